/* rtl/lmd_pkg.sv */
// Shared constants, register indexes and fixed-point helpers for the
// lens distortion map. No dependencies.
package lmd_pkg;

    // Largest image side; coordinates above MAX_DIM-1 are clamped.
    localparam int unsigned MAX_DIM  = 4096;
    // Cycles through the normalizing divider, including its output register.
    localparam int unsigned NORM_LAT = 34;
    // Stages after the divider, the output register included.
    localparam int unsigned TAIL_LAT = 15;
    localparam int unsigned LAT      = NORM_LAT + TAIL_LAT;

    // 1.0 in signed Q4.28.
    localparam logic signed [39:0] Q_ONE = 40'sd268435456;

    typedef enum logic [2:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_RADIAL_K1 = 3'd4,
        CFG_RADIAL_K2 = 3'd5,
        CFG_RADIAL_K3 = 3'd6,
        CFG_TANGENT   = 3'd7
    } t_cfg_idx;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Shift a product right with truncation toward zero, then saturate.
    function automatic logic signed [31:0] mq(input logic signed [63:0] p,
                                              input logic [4:0] sh);
        logic [63:0]        mag;
        logic [63:0]        m;
        logic signed [31:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        m   = mag >> sh;
        if (!p[63] && m > 64'd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (p[63] && m > 64'd2147483648) begin
            r = 32'sh8000_0000;
        end else if (p[63]) begin
            r = -$signed(m[31:0]);
        end else begin
            r = $signed(m[31:0]);
        end
        return r;
    endfunction

endpackage

/* rtl/lmd_norm.sv */
// Pipelined normalizer: (coord<<16 - center) * 2^28 / focal as signed Q4.28.
// One quotient bit per stage, restoring division. Depends on lmd_pkg.
module lmd_norm (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [11:0]        i_coord,
    input  logic [27:0]        i_center,
    input  logic [31:0]        i_focal,
    output logic signed [31:0] o_norm
);
    import lmd_pkg::*;

    localparam int QB = 32;

    logic [31:0] r_rem [0:QB];
    logic [31:0] r_q   [0:QB];
    logic [3:0]  r_nib [0:QB];
    logic        r_ovf [0:QB];
    logic        r_neg [0:QB];
    logic        r_mz  [0:QB];
    logic signed [31:0] r_out;

    logic signed [28:0] diff;
    logic [27:0]        mag;

    // Offset from the principal point and its magnitude.
    always_comb begin
        diff = $signed({1'b0, i_coord, 16'b0}) - $signed({1'b0, i_center});
        mag  = diff[28] ? 28'(-diff) : diff[27:0];
    end

    // First stage: the high dividend bits decide quotient overflow.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {8'b0, mag[27:4]};
            r_ovf[0] <= ({8'b0, mag[27:4]} >= i_focal);
            r_nib[0] <= mag[3:0];
            r_neg[0] <= diff[28];
            r_mz[0]  <= (mag == 28'd0);
            r_q[0]   <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic        bit_in;
        logic [32:0] trial;
        logic        ge;
        if (j <= 4) begin : g_nib
            assign bit_in = r_nib[j-1][4-j];
        end else begin : g_zero
            assign bit_in = 1'b0;
        end
        assign trial = {r_rem[j-1], bit_in};
        assign ge    = (trial >= {1'b0, i_focal});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? 32'(trial - {1'b0, i_focal}) : trial[31:0];
                r_q[j]   <= {r_q[j-1][30:0], ge};
                r_nib[j] <= r_nib[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
                r_mz[j]  <= r_mz[j-1];
            end
        end
    end

    // Apply the sign and saturate to Q4.28.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_mz[QB]) begin
                r_out <= '0;
            end else if (r_ovf[QB]) begin
                r_out <= r_neg[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else if (r_neg[QB]) begin
                r_out <= (r_q[QB] > 32'h8000_0000) ? 32'sh8000_0000
                                                    : -$signed(r_q[QB]);
            end else begin
                r_out <= r_q[QB][31] ? 32'sh7FFF_FFFF : $signed(r_q[QB]);
            end
        end
    end

    assign o_norm = r_out;

endmodule

/* rtl/lens_distortion_map.sv */
// Forward lens distortion map, radial and tangential terms, fixed point.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken. Reset clears the valid bits and
// loads the default registers (unit focal lengths, all else zero).
module lens_distortion_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [11:0] pixel_col, [23:12] pixel_row
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [31:0] map_col, [63:32] map_row
);
    import lmd_pkg::*;

    logic [31:0] r_fx, r_fy;
    logic [27:0] r_cx, r_cy;
    logic signed [31:0] r_k1, r_k2, r_k3;
    logic [63:0] r_tan;
    logic signed [31:0] p1, p2;

    logic        en;
    logic [LAT-1:0] r_vld;
    logic [11:0] col, row;
    logic [11:0] r_col [0:LAT-2];
    logic [11:0] r_row [0:LAT-2];
    logic signed [31:0] nx, ny;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx  <= 32'd65536;
            r_fy  <= 32'd65536;
            r_cx  <= '0;
            r_cy  <= '0;
            r_k1  <= '0;
            r_k2  <= '0;
            r_k3  <= '0;
            r_tan <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:   r_fx  <= i_cfg_data[31:0];
                CFG_FOCAL_Y:   r_fy  <= i_cfg_data[31:0];
                CFG_CENTER_X:  r_cx  <= i_cfg_data[27:0];
                CFG_CENTER_Y:  r_cy  <= i_cfg_data[27:0];
                CFG_RADIAL_K1: r_k1  <= i_cfg_data[31:0];
                CFG_RADIAL_K2: r_k2  <= i_cfg_data[31:0];
                CFG_RADIAL_K3: r_k3  <= i_cfg_data[31:0];
                CFG_TANGENT:   r_tan <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign p1 = r_tan[63:32];
    assign p2 = r_tan[31:0];

    // The pipeline moves unless a finished result waits at the output.
    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Clamp coordinates to the image.
    always_comb begin
        col = i_s_tdata[11:0];
        row = i_s_tdata[23:12];
        if ({5'b0, col} > 17'(MAX_DIM - 1)) col = 12'(MAX_DIM - 1);
        if ({5'b0, row} > 17'(MAX_DIM - 1)) row = 12'(MAX_DIM - 1);
    end

    // Coordinates ride along for the final mirror step.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col[0] <= col;
            r_row[0] <= row;
            for (int i = 1; i < LAT - 1; i++) begin
                r_col[i] <= r_col[i-1];
                r_row[i] <= r_row[i-1];
            end
        end
    end

    lmd_norm u_norm_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_coord  (col),
        .i_center (r_cx),
        .i_focal  (r_fx),
        .o_norm   (nx)
    );

    lmd_norm u_norm_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_coord  (row),
        .i_center (r_cy),
        .i_focal  (r_fy),
        .o_norm   (ny)
    );

    // Stage registers after the divider.
    logic signed [63:0] r_a_pxx, r_a_pyy, r_a_pxy;
    logic signed [31:0] r_a_x, r_a_y;
    logic signed [31:0] r_b_xx, r_b_yy, r_b_xy, r_b_x, r_b_y;
    logic signed [31:0] r_c_r2, r_c_2xy, r_c_xx, r_c_yy, r_c_x, r_c_y;
    logic signed [63:0] r_d_pr4, r_d_pk1;
    logic signed [31:0] r_d_ax, r_d_ay, r_d_r2, r_d_2xy, r_d_x, r_d_y;
    logic signed [31:0] r_e_r4, r_e_k1r2, r_e_r2, r_e_2xy, r_e_ax, r_e_ay;
    logic signed [31:0] r_e_x, r_e_y;
    logic signed [63:0] r_f_pr6, r_f_pk2;
    logic signed [31:0] r_f_k1r2, r_f_2xy, r_f_ax, r_f_ay, r_f_x, r_f_y;
    logic signed [31:0] r_g_r6, r_g_k2r4, r_g_k1r2, r_g_2xy, r_g_ax, r_g_ay;
    logic signed [31:0] r_g_x, r_g_y;
    logic signed [63:0] r_h_pk3;
    logic signed [31:0] r_h_k1r2, r_h_k2r4, r_h_2xy, r_h_ax, r_h_ay, r_h_x, r_h_y;
    logic signed [31:0] r_i_k3r6, r_i_k1r2, r_i_k2r4, r_i_2xy, r_i_ax, r_i_ay;
    logic signed [31:0] r_i_x, r_i_y;
    logic signed [31:0] r_j_rad, r_j_2xy, r_j_ax, r_j_ay, r_j_x, r_j_y;
    logic signed [63:0] r_k_pxr, r_k_px1, r_k_px2, r_k_pyr, r_k_py1, r_k_py2;
    logic signed [31:0] r_l_xr, r_l_x1, r_l_x2, r_l_yr, r_l_y1, r_l_y2;
    logic signed [31:0] r_m_xn, r_m_yn;
    logic [63:0]        r_n_pmx, r_n_pmy;
    logic               r_n_sx, r_n_sy;
    logic signed [31:0] r_o_col, r_o_row;

    logic [31:0]        mag_xn, mag_yn;
    logic signed [39:0] dx, dy, ox, oy;

    assign mag_xn = r_m_xn[31] ? 32'(-r_m_xn) : r_m_xn;
    assign mag_yn = r_m_yn[31] ? 32'(-r_m_yn) : r_m_yn;

    // Back to pixels and mirror the displacement.
    always_comb begin
        dx = r_n_sx ? -$signed({4'b0, r_n_pmx[63:28]}) : $signed({4'b0, r_n_pmx[63:28]});
        dy = r_n_sy ? -$signed({4'b0, r_n_pmy[63:28]}) : $signed({4'b0, r_n_pmy[63:28]});
        dx = dx + $signed({12'b0, r_cx});
        dy = dy + $signed({12'b0, r_cy});
        ox = $signed({11'b0, r_col[LAT-2], 17'b0}) - dx;
        oy = $signed({11'b0, r_row[LAT-2], 17'b0}) - dy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Squares and cross product.
            r_a_pxx <= nx * nx;
            r_a_pyy <= ny * ny;
            r_a_pxy <= nx * ny;
            r_a_x   <= nx;
            r_a_y   <= ny;
            r_b_xx  <= mq(r_a_pxx, 5'd28);
            r_b_yy  <= mq(r_a_pyy, 5'd28);
            r_b_xy  <= mq(r_a_pxy, 5'd28);
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            // Radius squared and doubled cross term.
            r_c_r2  <= sat40(40'(r_b_xx) + 40'(r_b_yy));
            r_c_2xy <= sat40(40'(r_b_xy) + 40'(r_b_xy));
            r_c_xx  <= r_b_xx;
            r_c_yy  <= r_b_yy;
            r_c_x   <= r_b_x;
            r_c_y   <= r_b_y;
            // r4 and k1 products; tangential sums.
            r_d_pr4 <= r_c_r2 * r_c_r2;
            r_d_pk1 <= r_k1 * r_c_r2;
            r_d_ax  <= sat40(40'(r_c_r2) + 40'(r_c_xx) + 40'(r_c_xx));
            r_d_ay  <= sat40(40'(r_c_r2) + 40'(r_c_yy) + 40'(r_c_yy));
            r_d_r2  <= r_c_r2;
            r_d_2xy <= r_c_2xy;
            r_d_x   <= r_c_x;
            r_d_y   <= r_c_y;
            r_e_r4   <= mq(r_d_pr4, 5'd28);
            r_e_k1r2 <= mq(r_d_pk1, 5'd24);
            r_e_r2   <= r_d_r2;
            r_e_2xy  <= r_d_2xy;
            r_e_ax   <= r_d_ax;
            r_e_ay   <= r_d_ay;
            r_e_x    <= r_d_x;
            r_e_y    <= r_d_y;
            // r6 and k2 products.
            r_f_pr6  <= r_e_r4 * r_e_r2;
            r_f_pk2  <= r_k2 * r_e_r4;
            r_f_k1r2 <= r_e_k1r2;
            r_f_2xy  <= r_e_2xy;
            r_f_ax   <= r_e_ax;
            r_f_ay   <= r_e_ay;
            r_f_x    <= r_e_x;
            r_f_y    <= r_e_y;
            r_g_r6   <= mq(r_f_pr6, 5'd28);
            r_g_k2r4 <= mq(r_f_pk2, 5'd24);
            r_g_k1r2 <= r_f_k1r2;
            r_g_2xy  <= r_f_2xy;
            r_g_ax   <= r_f_ax;
            r_g_ay   <= r_f_ay;
            r_g_x    <= r_f_x;
            r_g_y    <= r_f_y;
            // k3 product.
            r_h_pk3  <= r_k3 * r_g_r6;
            r_h_k1r2 <= r_g_k1r2;
            r_h_k2r4 <= r_g_k2r4;
            r_h_2xy  <= r_g_2xy;
            r_h_ax   <= r_g_ax;
            r_h_ay   <= r_g_ay;
            r_h_x    <= r_g_x;
            r_h_y    <= r_g_y;
            r_i_k3r6 <= mq(r_h_pk3, 5'd24);
            r_i_k1r2 <= r_h_k1r2;
            r_i_k2r4 <= r_h_k2r4;
            r_i_2xy  <= r_h_2xy;
            r_i_ax   <= r_h_ax;
            r_i_ay   <= r_h_ay;
            r_i_x    <= r_h_x;
            r_i_y    <= r_h_y;
            // Radial factor.
            r_j_rad  <= sat40(Q_ONE + 40'(r_i_k1r2) + 40'(r_i_k2r4) + 40'(r_i_k3r6));
            r_j_2xy  <= r_i_2xy;
            r_j_ax   <= r_i_ax;
            r_j_ay   <= r_i_ay;
            r_j_x    <= r_i_x;
            r_j_y    <= r_i_y;
            // Distorted coordinate terms.
            r_k_pxr <= r_j_x * r_j_rad;
            r_k_px1 <= p1 * r_j_2xy;
            r_k_px2 <= p2 * r_j_ax;
            r_k_pyr <= r_j_y * r_j_rad;
            r_k_py1 <= p1 * r_j_ay;
            r_k_py2 <= p2 * r_j_2xy;
            r_l_xr  <= mq(r_k_pxr, 5'd28);
            r_l_x1  <= mq(r_k_px1, 5'd24);
            r_l_x2  <= mq(r_k_px2, 5'd24);
            r_l_yr  <= mq(r_k_pyr, 5'd28);
            r_l_y1  <= mq(r_k_py1, 5'd24);
            r_l_y2  <= mq(r_k_py2, 5'd24);
            r_m_xn  <= sat40(40'(r_l_xr) + 40'(r_l_x1) + 40'(r_l_x2));
            r_m_yn  <= sat40(40'(r_l_yr) + 40'(r_l_y1) + 40'(r_l_y2));
            // Scale back by the focal lengths.
            r_n_pmx <= 64'(mag_xn) * 64'(r_fx);
            r_n_pmy <= 64'(mag_yn) * 64'(r_fy);
            r_n_sx  <= r_m_xn[31];
            r_n_sy  <= r_m_yn[31];
            // Output register.
            r_o_col <= sat40(ox);
            r_o_row <= sat40(oy);
        end
    end

    assign o_m_tdata = {r_o_row, r_o_col};

endmodule
